// ----- rtl/core/ddo_pkg.sv -----
// Package for the differential-drive odometry core: widths, CORDIC table,
// constants, state enum and CORDIC control struct. No dependencies.
package ddo_pkg;

  localparam int PosW   = 32;
  localparam int AngW   = 24;
  localparam int AngSh  = 30 - (AngW - 4);
  localparam int Iters  = 28;
  localparam int ItW    = 5;

  localparam logic signed [35:0] PiFileQ30 = 36'sd3373259368;
  localparam logic signed [35:0] PiTrueQ30 = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] GainQ30   = 36'sd652032874;

  localparam logic [1:0] RegMpt = 2'd0;
  localparam logic [1:0] RegRad = 2'd1;
  localparam logic [1:0] RegIwb = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VEL1, ST_VEL2, ST_VEL3, ST_VEL4, ST_SQRT, ST_ATAN,
    ST_AVG, ST_SINCOS, ST_POS, ST_DONE
  } ddo_state_e;

  function automatic logic signed [35:0] atan_q30(input logic [ItW-1:0] i);
    case (i)
      5'd0: atan_q30 = 36'sd843314856;  5'd1: atan_q30 = 36'sd497837829;
      5'd2: atan_q30 = 36'sd263043836;  5'd3: atan_q30 = 36'sd133525158;
      5'd4: atan_q30 = 36'sd67021686;   5'd5: atan_q30 = 36'sd33543515;
      5'd6: atan_q30 = 36'sd16775850;   5'd7: atan_q30 = 36'sd8388437;
      5'd8: atan_q30 = 36'sd4194282;    5'd9: atan_q30 = 36'sd2097149;
      5'd10: atan_q30 = 36'sd1048575;   5'd11: atan_q30 = 36'sd524287;
      5'd12: atan_q30 = 36'sd262143;    5'd13: atan_q30 = 36'sd131071;
      5'd14: atan_q30 = 36'sd65535;     5'd15: atan_q30 = 36'sd32767;
      5'd16: atan_q30 = 36'sd16383;     5'd17: atan_q30 = 36'sd8191;
      5'd18: atan_q30 = 36'sd4095;      5'd19: atan_q30 = 36'sd2047;
      5'd20: atan_q30 = 36'sd1023;      5'd21: atan_q30 = 36'sd511;
      5'd22: atan_q30 = 36'sd255;       5'd23: atan_q30 = 36'sd127;
      5'd24: atan_q30 = 36'sd63;        5'd25: atan_q30 = 36'sd31;
      5'd26: atan_q30 = 36'sd15;        5'd27: atan_q30 = 36'sd7;
      default: atan_q30 = 36'sd0;
    endcase
  endfunction

  typedef struct packed {
    logic       start;
    logic [1:0] mode;   // 0 atan2 (vectoring), 1 sincos (rotation)
  } ddo_cordic_ctl_t;

  localparam logic [1:0] ModeAtan = 2'd0;
  localparam logic [1:0] ModeRot  = 2'd1;

endpackage

// ----- rtl/core/ddo_serial_mult.sv -----
// Shift-add multiplier, one multiplier bit per cycle (signed 48 x unsigned 32).
// Depends on ddo_pkg.
module ddo_serial_mult (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] a_i,
  input  logic        [31:0] b_i,
  output logic               done_o,
  output logic signed [79:0] p_o
);
  import ddo_pkg::*;

  logic signed [79:0] acc_q, acc_d;
  logic signed [79:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q; a_d = a_q; b_d = b_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; a_d = 80'(a_i); b_d = b_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d = a_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ----- rtl/core/ddo_isqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle (64-bit in).
// Depends on ddo_pkg.
module ddo_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import ddo_pkg::*;

  logic [63:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] trial;

  always_comb begin
    rem_d = rem_q; res_d = res_q; bit_d = bit_q; busy_d = busy_q; done_d = 1'b0;
    trial = res_q + bit_q;
    if (start_i) begin
      rem_d = n_i; res_d = '0; bit_d = 64'd1 << 62; busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d; bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];
endmodule

// ----- rtl/core/ddo_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle: vectoring (atan2) or
// rotation (sin/cos). Depends on ddo_pkg.
module ddo_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ddo_pkg::ddo_cordic_ctl_t  ctl_i,
  input  logic signed [35:0]        x_i,
  input  logic signed [35:0]        y_i,
  input  logic signed [35:0]        z_i,
  output logic                      done_o,
  output logic signed [35:0]        x_o,
  output logic signed [35:0]        y_o,
  output logic signed [35:0]        z_o
);
  import ddo_pkg::*;

  logic signed [35:0] x_q, x_d, y_q, y_d, z_q, z_d, xs, ys, at;
  logic [ItW-1:0] it_q, it_d;
  logic [1:0]     mode_q, mode_d;
  logic           busy_q, busy_d, done_q, done_d, dir;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q; mode_d = mode_q;
    busy_d = busy_q; done_d = 1'b0;
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    at = atan_q30(it_q);
    dir = (mode_q == ModeAtan) ? (y_q >= 0) : (z_q >= 0);
    if (ctl_i.start) begin
      x_d = x_i; y_d = y_i; z_d = z_i; it_d = '0; mode_d = ctl_i.mode;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mode_q == ModeAtan) begin
        if (dir) begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
        end
      end else begin
        if (dir) begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
        end else begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
        end
      end
      it_d = it_q + 5'd1;
      if (it_q == ItW'(Iters - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; it_q <= '0; mode_q <= ModeAtan;
    end else begin
      busy_q <= busy_d; done_q <= done_d; it_q <= it_d; mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

// ----- rtl/core/diff_drive_odometry_core.sv -----
// Differential-drive wheel odometry core.
// Each transaction runs nine serial 32-step multiplies, one 32-step square
// root and two 28-step CORDIC passes; when the arcsine argument is rejected
// it goes to the result after the sixth multiply. One transaction in flight;
// a new one is taken only once the last result is in the output register.
// Async active-low reset clears pose, registers to defaults.
module diff_drive_odometry_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [23:0] left_distance, [47:24] right_distance,
  // [71:48] left_tick_rate, [95:72] right_tick_rate
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] pose_x, [63:32] pose_y, [86:64] heading,
  // [110:87] linear_velocity, [134:111] angular_velocity, [135] rejected
  output logic [135:0] m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ddo_pkg::*;

  // ---- configuration registers ----
  logic [31:0] mpt_q;
  logic [19:0] rad_q, iwb_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpt_q <= 32'd1431656; rad_q <= 20'd8192; iwb_q <= 20'd65536;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegMpt:  mpt_q <= pwdata;
        RegRad:  rad_q <= pwdata[19:0];
        RegIwb:  iwb_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMpt:  prdata = mpt_q;
      RegRad:  prdata = {12'd0, rad_q};
      RegIwb:  prdata = {12'd0, iwb_q};
      default: prdata = '0;
    endcase
  end

  // ---- state ----
  ddo_state_e st_q, st_d;
  logic signed [PosW-1:0] px_q, px_d, py_q, py_d;
  logic signed [AngW-1:0] hd_q, hd_d;
  logic signed [23:0] dl_q, dr_q, tl_q, tr_q;
  logic signed [35:0] a_q, a_d, co_q, co_d, si_q, si_d, turn_q, turn_d;
  logic        rej_q, rej_d, neg_q, neg_d;
  logic signed [23:0] lin_q, lin_d, ang_q, ang_d;
  logic [2:0]  ph_q, ph_d;             // sub-phase inside a state
  logic        ovalid_q, ovalid_d;
  logic [135:0] odata_q, odata_d;

  // shared units
  logic               m_start, m_done;
  logic signed [47:0] m_a;
  logic        [31:0] m_b;
  logic signed [79:0] m_p;
  logic               q_start, q_done;
  logic [63:0]        q_n;
  logic [31:0]        q_root;
  ddo_cordic_ctl_t    c_ctl;
  logic signed [35:0] cx_i, cy_i, cz_i, cx_o, cy_o, cz_o;
  logic               c_done;

  ddo_serial_mult u_mult (.clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
                          .done_o(m_done), .p_o(m_p));
  ddo_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(q_start), .n_i(q_n),
                    .done_o(q_done), .root_o(q_root));
  ddo_cordic u_cordic (.clk_i, .rst_ni, .ctl_i(c_ctl), .x_i(cx_i), .y_i(cy_i),
                       .z_i(cz_i), .done_o(c_done), .x_o(cx_o), .y_o(cy_o), .z_o(cz_o));

  // round half up by 16/17/37 etc.
  function automatic logic signed [79:0] rsh(input logic signed [79:0] v,
                                             input logic [5:0] s);
    rsh = (v + (80'sd1 <<< (s - 6'd1))) >>> s;
  endfunction

  function automatic logic signed [79:0] sat(input logic signed [79:0] v,
                                             input logic [5:0] w);
    logic signed [79:0] hi, lo;
    hi = (80'sd1 <<< (w - 6'd1)) - 80'sd1;
    lo = -hi - 80'sd1;
    sat = (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  logic signed [24:0] ddiff;
  logic signed [79:0] prod, one38, avg, hsum, tmp, pia;
  assign ddiff = 25'(dr_q) - 25'(dl_q);
  assign one38 = 80'sd1 <<< 38;
  assign pia   = (80'(PiFileQ30) + (80'sd1 <<< (AngSh - 1))) >>> AngSh;
  // the output register parts the two sides: a held result does not block taking the next input, only its ST_DONE
  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  always_comb begin
    st_d = st_q; px_d = px_q; py_d = py_q; hd_d = hd_q;
    a_d = a_q; co_d = co_q; si_d = si_q; turn_d = turn_q;
    rej_d = rej_q; neg_d = neg_q; lin_d = lin_q; ang_d = ang_q; ph_d = ph_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    m_start = 1'b0; m_a = '0; m_b = '0;
    q_start = 1'b0; q_n = '0;
    c_ctl = '0; cx_i = '0; cy_i = '0; cz_i = '0;
    prod = '0; avg = '0; hsum = '0; tmp = '0;
    if (ovalid_q && m_axis_tready_i) ovalid_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          st_d = ST_VEL1; ph_d = '0;
        end
      end
      ST_VEL1: begin  // (tl+tr)*mpt
        if (ph_q == 3'd0) begin
          m_start = 1'b1; m_a = 48'(25'(tl_q) + 25'(tr_q)); m_b = mpt_q; ph_d = 3'd1;
        end else if (m_done) begin
          m_start = 1'b1; m_a = 48'(rsh(m_p, 6'd16)); m_b = 32'(rad_q);
          st_d = ST_VEL2; ph_d = '0;
        end
      end
      ST_VEL2: begin
        if (m_done) begin
          lin_d = 24'(sat(rsh(m_p, 6'd17), 6'd24));
          m_start = 1'b1; m_a = 48'(25'(tr_q) - 25'(tl_q)); m_b = mpt_q;
          st_d = ST_VEL3;
        end
      end
      ST_VEL3: begin
        if (m_done) begin
          if (ph_q == 3'd0) begin
            m_start = 1'b1; m_a = 48'(rsh(m_p, 6'd16)); m_b = 32'(rad_q); ph_d = 3'd1;
          end else begin
            m_start = 1'b1; m_a = 48'(sat(rsh(m_p, 6'd16), 6'd43)); m_b = 32'(iwb_q);
            st_d = ST_VEL4; ph_d = '0;
          end
        end
      end
      ST_VEL4: begin
        if (m_done) begin
          ang_d = 24'(sat(rsh(m_p, 6'd16), 6'd24));
          m_start = 1'b1; m_a = 48'(ddiff); m_b = 32'(iwb_q);
          st_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (ph_q == 3'd0) begin
          if (m_done) begin
            prod = m_p;
            rej_d = (prod > one38) || (prod < -one38);
            a_d = 36'(rsh(prod, 6'd8));
            if ((prod > one38) || (prod < -one38)) st_d = ST_DONE;
            else ph_d = 3'd1;
          end
        end else if (ph_q == 3'd1) begin  // a*a by the serial multiplier
          m_start = 1'b1; m_a = 48'(a_q < 0 ? -a_q : a_q);
          m_b = 32'(a_q < 0 ? -a_q : a_q); ph_d = 3'd2;
        end else if (ph_q == 3'd2) begin
          if (m_done) begin
            q_start = 1'b1; q_n = (64'd1 << 60) - 64'(m_p); ph_d = 3'd3;
          end
        end else if (q_done) begin
          c_ctl.start = 1'b1; c_ctl.mode = ModeAtan;
          cx_i = 36'(q_root); cy_i = a_q; cz_i = '0;
          st_d = ST_ATAN; ph_d = '0;
        end
      end
      ST_ATAN: begin
        if (c_done) begin
          turn_d = cz_o;
          st_d = ST_AVG;
        end
      end
      ST_AVG: begin
        avg = rsh(80'(turn_q), 6'd1) + (80'(hd_q) <<< AngSh);
        if (avg > 80'(PiFileQ30)) avg = avg - 80'(PiFileQ30) * 2;
        else if (avg < -80'(PiFileQ30)) avg = avg + 80'(PiFileQ30) * 2;
        neg_d = 1'b0;
        if (avg > 80'(HalfPiQ30)) begin
          avg = avg - 80'(PiTrueQ30); neg_d = 1'b1;
        end else if (avg < -80'(HalfPiQ30)) begin
          avg = avg + 80'(PiTrueQ30); neg_d = 1'b1;
        end
        c_ctl.start = 1'b1; c_ctl.mode = ModeRot;
        cx_i = GainQ30; cy_i = '0; cz_i = 36'(avg);
        st_d = ST_SINCOS;
      end
      ST_SINCOS: begin
        if (c_done) begin
          co_d = neg_q ? -cx_o : cx_o;
          si_d = neg_q ? -cy_o : cy_o;
          st_d = ST_POS; ph_d = '0;
        end
      end
      ST_POS: begin
        hsum = 80'(dl_q) + 80'(dr_q);
        if (ph_q == 3'd0) begin  // |sum| * co, sign fixed afterwards
          m_start = 1'b1; m_a = 48'(co_q);
          m_b = 32'(hsum < 0 ? -hsum : hsum); ph_d = 3'd1;
        end else if (ph_q == 3'd1) begin
          if (m_done) begin
            tmp = hsum < 0 ? -m_p : m_p;
            px_d = PosW'(sat(80'(px_q) + rsh(tmp, 6'd37), 6'(PosW)));
            m_start = 1'b1; m_a = 48'(si_q);
            m_b = 32'(hsum < 0 ? -hsum : hsum); ph_d = 3'd2;
          end
        end else if (m_done) begin
          tmp = hsum < 0 ? -m_p : m_p;
          py_d = PosW'(sat(80'(py_q) + rsh(tmp, 6'd37), 6'(PosW)));
          tmp = 80'(hd_q) + rsh(80'(turn_q), 6'(AngSh));
          if (tmp > pia) tmp = tmp - pia * 2;
          else if (tmp < -pia) tmp = tmp + pia * 2;
          hd_d = AngW'(sat(tmp, 6'(AngW)));
          st_d = ST_DONE; ph_d = '0;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d = {rej_q, ang_q, lin_q, hd_q[22:0], py_q[31:0], px_q[31:0]};
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; px_q <= '0; py_q <= '0; hd_q <= '0;
      ph_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; px_q <= px_d; py_q <= py_d; hd_q <= hd_d;
      ph_q <= ph_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && s_axis_tvalid_i && s_axis_tready_o) begin
      dl_q <= s_axis_tdata_i[23:0];  dr_q <= s_axis_tdata_i[47:24];
      tl_q <= s_axis_tdata_i[71:48]; tr_q <= s_axis_tdata_i[95:72];
    end
    a_q <= a_d; co_q <= co_d; si_q <= si_d;
    turn_q <= turn_d; rej_q <= rej_d; neg_q <= neg_d; lin_q <= lin_d;
    ang_q <= ang_d; odata_q <= odata_d;
  end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for diff_drive_odometry_core: streams wheel updates,
// predicts pose and velocities in-line, and checks every result transaction.
// Depends on ddo_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ddo_pkg::*;

  localparam longint ONE = 64'sd1;
  localparam longint PI_Q30 = 64'sd3373259368;
  localparam longint PI_REAL_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam int HEAD_SHIFT = 10;       // Q30 angle down to heading fraction bits
  localparam int DRAIN_CYCLES = 400;    // covers one transaction in flight
  localparam longint CYCLE_LIMIT = 2000000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  // [23:0] left_distance, [47:24] right_distance,
  // [71:48] left_tick_rate, [95:72] right_tick_rate
  logic [95:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  // [31:0] pose_x, [63:32] pose_y, [86:64] heading,
  // [110:87] linear_velocity, [134:111] angular_velocity, [135] rejected
  logic [135:0] m_axis_tdata_o;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  diff_drive_odometry_core dut (.*);

  // micro-rotation angles, Q2.30
  longint rot_angle [28] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7
  };

  // predictor state: registers and pose
  logic [31:0]  m_per_tick;
  logic [19:0]  radius;
  logic [19:0]  inv_base;
  longint       pos_x, pos_y, head;

  logic [135:0] pending_results[$];
  int           errors;
  bit           gaps_on;
  bit           hold_req;
  int           burst_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- fixed-point helpers ----------------
  function automatic longint round_shift(longint v, int s);
    return (v + (ONE << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (ONE << (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC: atan2(y, x), x >= 0
  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += rot_angle[i];
      end else begin
        x = x - ys; y = y + xs; z -= rot_angle[i];
      end
    end
    return z;
  endfunction

  // rotation CORDIC; folds the angle into +-pi/2 with true pi
  task automatic rotate_unit(input longint a, output longint co, output longint si);
    longint x, y, z, xs, ys;
    bit flip;
    x = GAIN_Q30; y = 0; z = a; flip = 0;
    if (z > HALF_PI_Q30) begin
      z -= PI_REAL_Q30; flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_REAL_Q30; flip = 1;
    end
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= rot_angle[i];
      end else begin
        x = x + ys; y = y - xs; z += rot_angle[i];
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  // advances the pose by one wheel update and returns the packed result
  task automatic advance_pose(input logic [95:0] d, output logic [135:0] r);
    longint dl, dr, tl, tr, prod, v, lin, ang, a, c, turn, avg, co, si, h, pi_h;
    longint unsigned aa;
    bit rej;
    dl = longint'($signed(d[23:0]));
    dr = longint'($signed(d[47:24]));
    tl = longint'($signed(d[71:48]));
    tr = longint'($signed(d[95:72]));
    prod = (dr - dl) * longint'(inv_base);
    rej = prod > (ONE << 38) || prod < -(ONE << 38);
    pi_h = (PI_Q30 + (ONE << (HEAD_SHIFT - 1))) >>> HEAD_SHIFT;

    v = round_shift((tl + tr) * longint'(m_per_tick), 16);
    lin = clamp(round_shift(v * longint'(radius), 17), 24);
    v = round_shift((tr - tl) * longint'(m_per_tick), 16);
    v = clamp(round_shift(v * longint'(radius), 16), 43);
    ang = clamp(round_shift(v * longint'(inv_base), 16), 24);

    if (!rej) begin
      a = round_shift(prod, 8);
      aa = longint'(a < 0 ? -a : a);
      c = int_sqrt((64'd1 << 60) - aa * aa);
      turn = vector_angle(a, c);
      avg = round_shift(turn, 1) + (head <<< HEAD_SHIFT);
      if (avg > PI_Q30) avg -= 2 * PI_Q30;
      else if (avg < -PI_Q30) avg += 2 * PI_Q30;
      rotate_unit(avg, co, si);
      pos_x = clamp(pos_x + round_shift(co * (dl + dr), 37), 32);
      pos_y = clamp(pos_y + round_shift(si * (dl + dr), 37), 32);
      h = head + round_shift(turn, HEAD_SHIFT);
      if (h > pi_h) h -= 2 * pi_h;
      else if (h < -pi_h) h += 2 * pi_h;
      head = clamp(h, 24);
    end
    r = {rej, ang[23:0], lin[23:0], head[22:0], pos_y[31:0], pos_x[31:0]};
  endtask

  // ---------------- result checker ----------------
  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    logic [135:0] e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: 0x%0h", m_axis_tdata_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("pose_x", e[31:0], m_axis_tdata_o[31:0]);
        check_field("pose_y", e[63:32], m_axis_tdata_o[63:32]);
        check_field("heading", e[86:64], m_axis_tdata_o[86:64]);
        check_field("linear_velocity", e[110:87], m_axis_tdata_o[110:87]);
        check_field("angular_velocity", e[134:111], m_axis_tdata_o[134:111]);
        check_field("rejected", e[135], m_axis_tdata_o[135]);
      end
    end
  end

  // receiver: stalls in phases, plus a long hold-off on request
  initial begin
    int hold_left, phase_left;
    bit stalling;
    hold_left = 0; phase_left = 0; stalling = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 3000;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(1500, 200);
        stalling = $urandom_range(1);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = stalling ? ($urandom_range(3) == 0) : 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------- stimulus tasks ----------------
  task automatic send_update(input logic [95:0] d);
    logic [135:0] r;
    int gap;
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(12, 1);
        gap = $urandom_range(40, 1);
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left--;
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    advance_pose(d, r);
    pending_results.push_back(r);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic wait_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    stop_sending();
    wait_results();
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      RegMpt: m_per_tick = val;
      RegRad: radius = val[19:0];
      RegIwb: inv_base = val[19:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] mpt, input logic [19:0] rad,
                          input logic [19:0] iwb);
    write_reg(RegMpt, mpt);
    write_reg(RegRad, {12'd0, rad});
    write_reg(RegIwb, {12'd0, iwb});
  endtask

  function automatic logic [95:0] pack_update(longint dl, longint dr, longint tl,
                                              longint tr);
    return {tr[23:0], tl[23:0], dr[23:0], dl[23:0]};
  endfunction

  // random update; well-formed ones keep the arcsine argument within one
  function automatic logic [95:0] random_update(bit well_formed);
    longint lim, diff, dl, dr;
    logic [95:0] d;
    d = {$urandom(), $urandom(), $urandom()};
    if (!well_formed) return d;
    lim = (ONE << 38) / longint'(inv_base == 0 ? 20'd1 : inv_base);
    if (lim > (ONE << 24) - 1) lim = (ONE << 24) - 1;
    diff = longint'($urandom_range(32'(2 * lim))) - lim;
    dl = longint'($signed(d[23:0]));
    if ($urandom_range(3) == 0) dl = dl >>> $urandom_range(20);
    dr = clamp(dl + diff, 24);
    return {d[95:48], dr[23:0], dl[23:0]};
  endfunction

  // extremes of every field and the arcsine edge cases at reset registers, then saturating and zero registers
  task automatic test_directed();
    send_update(pack_update(0, 0, 0, 0));
    send_update(pack_update(8388607, 8388607, 8388607, 8388607));
    send_update(pack_update(-8388608, -8388608, -8388608, -8388608));
    send_update(pack_update(-8388608, 8388607, -8388608, 8388607));
    send_update(pack_update(8388607, -8388608, 8388607, -8388608));
    // argument exactly +1 and -1 with inverse base of one
    send_update(pack_update(0, 4194304, 100, 200));
    send_update(pack_update(4194304, 0, -100, 200));
    // argument just above one: pose kept, flag raised
    send_update(pack_update(0, 4194305, 5000, -5000));
    send_update(pack_update(4194305, 0, -5000, 5000));
    send_update(pack_update(-8388608, 8388607, 0, 0));
    // quarter turns wrap the heading past pi
    repeat (6) send_update(pack_update(-2097152, 2097152, 10, 10));
    repeat (6) send_update(pack_update(2097152, -2097152, -10, 10));
    // velocity saturation
    set_regs(32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF);
    send_update(pack_update(1, 2, 8388607, 8388607));
    send_update(pack_update(2, 1, -8388608, 8388607));
    send_update(pack_update(3, 3, -8388608, -8388608));
    // zero registers give zero products
    set_regs(32'd0, 20'd0, 20'd0);
    send_update(pack_update(8388607, -8388608, 8388607, -8388608));
    send_update(pack_update(1048576, 1048576, 1000, 2000));
    stop_sending();
  endtask

  task automatic run_random(int count);
    repeat (count) send_update(random_update($urandom_range(9) != 0));
  endtask

  // random traffic across register settings, extremes included
  task automatic test_random();
    set_regs(32'd1431656, 20'd8192, 20'd65536);
    gaps_on = 0;
    run_random(150);
    gaps_on = 1;
    run_random(150);
    set_regs(32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF);
    run_random(150);
    set_regs(32'd1, 20'd1, 20'd1);
    run_random(150);
    repeat (3) begin
      set_regs($urandom(), 20'($urandom_range(20'hFFFFF, 1)),
               20'($urandom_range(20'hFFFFF, 1)));
      gaps_on = $urandom_range(1);
      run_random(150);
    end
    stop_sending();
  endtask

  // output held off while input keeps coming; then sender waits for drain and sends with gaps
  task automatic test_backpressure();
    gaps_on = 0;
    hold_req = 1;
    run_random(20);
    stop_sending();
    wait_results();
    gaps_on = 1;
    run_random(30);
    stop_sending();
  endtask

  initial begin
    errors = 0; gaps_on = 0; hold_req = 0; burst_left = 0;
    s_axis_tvalid_i = 1'b0; s_axis_tdata_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    m_per_tick = 32'd1431656; radius = 20'd8192; inv_base = 20'd65536;
    pos_x = 0; pos_y = 0; head = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random();
    test_backpressure();

    wait_results();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
